[hdl/dgt_pkg.sv]
// Shared package for the delay-gradient trend detector.
// Holds field widths, operation and trend codes, register indexes and the stage-one struct.
// No dependencies.
package dgt_pkg;

	localparam int TS_W        = 48;
	localparam int OP_W        = 2;
	localparam int TREND_W     = 2;
	localparam int MIN_W       = 8;
	localparam int THR_W       = 10;
	localparam int CFG_IDX_W   = 2;
	localparam int CFG_DATA_W  = 10;

	localparam int WINDOW_DEPTH_DEF = 128;

	localparam logic [MIN_W-1:0] MIN_ENTRIES_RST = MIN_W'(50);
	localparam logic [THR_W-1:0] THRESHOLD_RST   = THR_W'(50);

	localparam logic [OP_W-1:0] OP_RECORD = 2'd0;
	localparam logic [OP_W-1:0] OP_QUERY  = 2'd1;
	localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

	localparam logic [TREND_W-1:0] TREND_HOLD     = 2'd0;
	localparam logic [TREND_W-1:0] TREND_INCREASE = 2'd1;
	localparam logic [TREND_W-1:0] TREND_DECREASE = 2'd2;

	localparam logic [CFG_IDX_W-1:0] CFG_MIN_ENTRIES = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD   = 2'd1;

	// (A - M) scaled to thousandths
	localparam logic signed [10:0] GRAD_SCALE = 11'sd1000;

	typedef struct packed {
		logic            hold;
		logic [TS_W-1:0] arr_new;
		logic [TS_W-1:0] arr_old;
		logic [TS_W-1:0] med_new;
		logic [TS_W-1:0] med_old;
	} dgt_s1_t;

endpackage

[hdl/dgt_trend_pipe.sv]
// Trend arithmetic pipeline: spans, excess, products, compare, output register.
// Bubble-collapsing stages with stall back-pressure to the window stage.
// Depends on dgt_pkg.
module dgt_trend_pipe (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s1_valid,
	input  dgt_pkg::dgt_s1_t           s1_data,
	output logic                       s1_take,
	input  logic [dgt_pkg::THR_W-1:0]  threshold_permille,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [dgt_pkg::TREND_W-1:0] trend
);
	import dgt_pkg::*;

	localparam int SPAN_W = TS_W + 1;
	localparam int EXC_W  = TS_W + 2;
	localparam int PROD_W = TS_W + 13;
	localparam int LIM_W  = TS_W + THR_W;

	logic                     v_s2, v_s3, v_s4, out_valid_q;
	logic                     ld_s2, ld_s3, ld_s4, ld_out;

	logic                     hold_s2, hold_s3, hold_s4;
	logic signed [SPAN_W-1:0] arr_span_s2, med_span_s2;
	logic signed [EXC_W-1:0]  excess_s3;
	logic [TS_W-1:0]          med_s3;
	logic signed [PROD_W-1:0] lhs_s4;
	logic [LIM_W-1:0]         limit_s4;
	logic [TREND_W-1:0]       trend_q;

	logic signed [PROD_W-1:0] limit_ext, limit_neg;
	logic [TREND_W-1:0]       trend_next;

	assign ld_out  = !out_valid_q || !out_stall;
	assign ld_s4   = !v_s4 || ld_out;
	assign ld_s3   = !v_s3 || ld_s4;
	assign ld_s2   = !v_s2 || ld_s3;
	assign s1_take = ld_s2;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s2        <= 1'b0;
			v_s3        <= 1'b0;
			v_s4        <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			if (ld_s2)
				v_s2 <= s1_valid;
			if (ld_s3)
				v_s3 <= v_s2;
			if (ld_s4)
				v_s4 <= v_s3;
			if (ld_out)
				out_valid_q <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld_s2) begin
			hold_s2     <= s1_data.hold;
			arr_span_s2 <= $signed({1'b0, s1_data.arr_new}) - $signed({1'b0, s1_data.arr_old});
			med_span_s2 <= $signed({1'b0, s1_data.med_new}) - $signed({1'b0, s1_data.med_old});
		end
		if (ld_s3) begin
			// media span must be strictly positive
			hold_s3   <= hold_s2 || med_span_s2[SPAN_W-1] || (med_span_s2 == '0);
			excess_s3 <= EXC_W'(arr_span_s2) - EXC_W'(med_span_s2);
			med_s3    <= med_span_s2[TS_W-1:0];
		end
		if (ld_s4) begin
			hold_s4  <= hold_s3;
			lhs_s4   <= PROD_W'(excess_s3) * PROD_W'(GRAD_SCALE);
			limit_s4 <= LIM_W'(threshold_permille) * LIM_W'(med_s3);
		end
		if (ld_out)
			trend_q <= trend_next;
	end

	assign limit_ext = $signed(PROD_W'(limit_s4));
	assign limit_neg = -limit_ext;

	always_comb begin
		priority if (hold_s4)
			trend_next = TREND_HOLD;
		else if (lhs_s4 > limit_ext)
			trend_next = TREND_DECREASE;
		else if (lhs_s4 < limit_neg)
			trend_next = TREND_INCREASE;
		else
			trend_next = TREND_HOLD;
	end

	assign out_valid = out_valid_q;
	assign trend     = trend_q;

endmodule

[hdl/delay_gradient_trend_detector_core.sv]
// Top level of the delay-gradient trend detector: packet window memory, indexes, config.
// Depends on dgt_pkg and dgt_trend_pipe.
//
//  channel | handshake               | payload
//  --------+-------------------------+--------------------------------------
//  in      | in_valid / in_stall     | operation, arrival_ms, media_ts_ms
//  out     | out_valid / out_stall   | trend
//  cfg     | cfg_valid / cfg_ready   | cfg_index, cfg_data
//
// One item per cycle while in_stall is low. Records and clears act at the accepting edge;
// a query reads the newest and oldest entries at its accepting edge; its trend then passes
// through spans, excess, products and compare into the output register.
// Five query stages collapse bubbles, so in_stall rises only once all of them hold items.
// Reset clears the write index, entry count and stage valids and sets both registers to 50;
// the window memory is not cleared.
module delay_gradient_trend_detector_core #(
	parameter int WINDOW_DEPTH = dgt_pkg::WINDOW_DEPTH_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           in_valid,
	output logic                           in_stall,
	input  logic [dgt_pkg::OP_W-1:0]       operation,
	input  logic [dgt_pkg::TS_W-1:0]       arrival_ms,
	input  logic [dgt_pkg::TS_W-1:0]       media_ts_ms,
	output logic                           out_valid,
	input  logic                           out_stall,
	output logic [dgt_pkg::TREND_W-1:0]    trend,
	input  logic                           cfg_valid,
	output logic                           cfg_ready,
	input  logic [dgt_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [dgt_pkg::CFG_DATA_W-1:0] cfg_data
);
	import dgt_pkg::*;

	localparam int IDX_W = (WINDOW_DEPTH > 1) ? $clog2(WINDOW_DEPTH) : 1;
	localparam int CNT_W = $clog2(WINDOW_DEPTH + 1);
	localparam int CMP_W = (CNT_W > MIN_W) ? CNT_W : MIN_W;

	logic [TS_W-1:0]  arrival_mem [WINDOW_DEPTH];
	logic [TS_W-1:0]  media_mem   [WINDOW_DEPTH];

	logic [IDX_W-1:0] wr_idx_q;
	logic [CNT_W-1:0] count_q;
	logic [MIN_W-1:0] min_entries_q;
	logic [THR_W-1:0] threshold_q;

	logic             in_acc, rec_acc, qry_acc, clr_acc;
	logic             v_s1, ld_s1, pipe_take;
	dgt_s1_t          data_s1;

	logic [IDX_W-1:0] newest_idx, oldest_idx, wr_idx_next;
	logic [CNT_W:0]   wr_ext, cnt_ext, oldest_full;
	logic             hold_now;

	assign cfg_ready = 1'b1;

	assign ld_s1    = !v_s1 || pipe_take;
	assign in_stall = !ld_s1;
	assign in_acc   = in_valid && ld_s1;
	assign rec_acc  = in_acc && (operation == OP_RECORD);
	assign qry_acc  = in_acc && (operation == OP_QUERY);
	assign clr_acc  = in_acc && (operation == OP_CLEAR);

	assign newest_idx  = (wr_idx_q == '0) ? IDX_W'(WINDOW_DEPTH - 1) : wr_idx_q - 1'b1;
	assign wr_ext      = (CNT_W + 1)'(wr_idx_q);
	assign cnt_ext     = (CNT_W + 1)'(count_q);
	assign oldest_full = (wr_ext >= cnt_ext) ? wr_ext - cnt_ext
	                                         : wr_ext + (CNT_W + 1)'(WINDOW_DEPTH) - cnt_ext;
	assign oldest_idx  = oldest_full[IDX_W-1:0];
	assign wr_idx_next = (wr_idx_q == IDX_W'(WINDOW_DEPTH - 1)) ? '0 : wr_idx_q + 1'b1;

	assign hold_now = (count_q == '0) || (CMP_W'(count_q) < CMP_W'(min_entries_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_idx_q      <= '0;
			count_q       <= '0;
			v_s1          <= 1'b0;
			min_entries_q <= MIN_ENTRIES_RST;
			threshold_q   <= THRESHOLD_RST;
		end else begin
			if (ld_s1)
				v_s1 <= qry_acc;
			if (rec_acc) begin
				wr_idx_q <= wr_idx_next;
				if (count_q != CNT_W'(WINDOW_DEPTH))
					count_q <= count_q + 1'b1;
			end else if (clr_acc) begin
				wr_idx_q <= '0;
				count_q  <= '0;
			end
			if (cfg_valid && cfg_ready) begin
				unique case (cfg_index)
					CFG_MIN_ENTRIES: min_entries_q <= cfg_data[MIN_W-1:0];
					CFG_THRESHOLD:   threshold_q   <= cfg_data[THR_W-1:0];
					default: ;
				endcase
			end
		end
	end

	// window memory: one write port, two registered read ports
	always_ff @(posedge clk) begin
		if (rec_acc) begin
			arrival_mem[wr_idx_q] <= arrival_ms;
			media_mem[wr_idx_q]   <= media_ts_ms;
		end
		if (qry_acc) begin
			data_s1.hold    <= hold_now;
			data_s1.arr_new <= arrival_mem[newest_idx];
			data_s1.arr_old <= arrival_mem[oldest_idx];
			data_s1.med_new <= media_mem[newest_idx];
			data_s1.med_old <= media_mem[oldest_idx];
		end
	end

	dgt_trend_pipe u_pipe (
		.clk                (clk),
		.arst_n             (arst_n),
		.s1_valid           (v_s1),
		.s1_data            (data_s1),
		.s1_take            (pipe_take),
		.threshold_permille (threshold_q),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.trend              (trend)
	);

endmodule
